// ===== hdl/hnorm_pkg.sv =====
// ----------------------------------------------------------------------------
// hnorm_pkg
// Shared types and constants of the heightfield normal generator: register
// indexes, the difference record that passes from front to back, and the
// state encodings of both sequencers.
// ----------------------------------------------------------------------------
package hnorm_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int DIFF_W    = 9;
  localparam int ROW_W     = 9;
  localparam int GAIN_W    = 16;
  localparam int MAG_W     = 24;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_GAIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_COMP     = 3'd4;

  // Register file contents.
  typedef struct packed {
    logic [ROW_W-1:0]  grid_width;
    logic [ROW_W-1:0]  grid_height;
    logic [GAIN_W-1:0] x_gain;
    logic [GAIN_W-1:0] z_gain;
    logic [GAIN_W-1:0] up_component;
  } hnorm_cfg_t;

  // Height differences of one grid point, handed from front to back.
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dz;
    logic                     last;
  } hnorm_diff_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_RD0,
    FR_RD1,
    FR_RD2,
    FR_RD3,
    FR_DONE
  } hnorm_front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_NORM,
    BK_SQ,
    BK_ROOT,
    BK_DLOAD,
    BK_DIV,
    BK_DONE
  } hnorm_back_state_t;

endpackage

// ===== hdl/hnorm_front.sv =====
// ----------------------------------------------------------------------------
// hnorm_front
// Accepts height samples and flush ticks, keeps the two line stores and the
// grid counters, fetches the neighbours of one grid point and hands its
// height differences to the queue.
// ----------------------------------------------------------------------------
module hnorm_front #(
  parameter int MAX_WIDTH = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_command,
  input  logic signed [hnorm_pkg::SAMPLE_W-1:0] in_height_sample,
  input  hnorm_pkg::hnorm_cfg_t                cfg,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output hnorm_pkg::hnorm_diff_t               push_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  hnorm_pkg::hnorm_front_state_t state_r, state_nxt;

  logic [CW-1:0]                   col_count_r, flush_col_r, col_r;
  logic [hnorm_pkg::ROW_W-1:0]     row_count_r, hgt;
  logic [CW-1:0]                   wm1, cnt_sel, col_in, prev_addr, old_addr;
  logic                            cmd_r, full, take, accept, produce, go, mem_we;
  logic [hnorm_pkg::SAMPLE_W-1:0]  raw_r, c_r, a_r, l_r, r_r, prev_q_r, old_q_r;
  logic [hnorm_pkg::SAMPLE_W-1:0]  left, right, above, below;

  logic [hnorm_pkg::SAMPLE_W-1:0]  prev_mem [MAX_WIDTH];
  logic [hnorm_pkg::SAMPLE_W-1:0]  old_mem  [MAX_WIDTH];

  // Width in use as last column index, height in use as at least two rows.
  always_comb begin
    if (int'(cfg.grid_width) >= MAX_WIDTH) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else if (cfg.grid_width < 9'd2) begin
      wm1 = CW'(1);
    end else begin
      wm1 = CW'(int'(cfg.grid_width) - 1);
    end
    hgt = (cfg.grid_height < 9'd2) ? 9'd2 : cfg.grid_height;
  end

  assign full    = (row_count_r >= hgt);
  assign cnt_sel = in_command ? flush_col_r : col_count_r;
  assign col_in  = (cnt_sel > wm1) ? wm1 : cnt_sel;
  assign take    = in_command ? full : !full;
  assign accept  = in_valid && in_ready;
  assign produce = cmd_r || (row_count_r != '0);
  assign go      = (state_r == hnorm_pkg::FR_DONE) && (!produce || push_ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hnorm_pkg::FR_IDLE: if (accept && take) state_nxt = hnorm_pkg::FR_RD0;
      hnorm_pkg::FR_RD0:  state_nxt = hnorm_pkg::FR_RD1;
      hnorm_pkg::FR_RD1:  state_nxt = hnorm_pkg::FR_RD2;
      hnorm_pkg::FR_RD2:  state_nxt = hnorm_pkg::FR_RD3;
      hnorm_pkg::FR_RD3:  state_nxt = hnorm_pkg::FR_DONE;
      hnorm_pkg::FR_DONE: if (go) state_nxt = hnorm_pkg::FR_IDLE;
      default:            state_nxt = hnorm_pkg::FR_IDLE;
    endcase
  end

  // Handshakes and line store addresses.
  always_comb begin
    in_ready   = (state_r == hnorm_pkg::FR_IDLE);
    push_valid = (state_r == hnorm_pkg::FR_DONE) && produce;
    mem_we     = go && !cmd_r;
    prev_addr  = col_r;
    old_addr   = col_r;
    unique case (state_r)
      hnorm_pkg::FR_RD1: begin
        if (col_r < wm1) prev_addr = col_r + CW'(1);
        if (col_r != '0) old_addr = col_r - CW'(1);
      end
      hnorm_pkg::FR_RD2: begin
        if (col_r != '0) prev_addr = col_r - CW'(1);
      end
      default: begin
        prev_addr = col_r;
      end
    endcase
  end

  // Line stores: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (mem_we) prev_mem[col_r] <= raw_r;
    prev_q_r <= prev_mem[prev_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) old_mem[col_r] <= c_r;
    old_q_r <= old_mem[old_addr];
  end

  // Transaction capture and neighbour collection.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      raw_r <= in_height_sample;
      col_r <= col_in;
    end
    if (state_r == hnorm_pkg::FR_RD1) begin
      c_r <= prev_q_r;
      a_r <= old_q_r;
    end
    if (state_r == hnorm_pkg::FR_RD2) begin
      r_r <= prev_q_r;
      l_r <= old_q_r;
    end
    if (state_r == hnorm_pkg::FR_RD3 && cmd_r) begin
      l_r <= prev_q_r;
    end
  end

  // Border handling: a missing neighbour is the centre sample.
  always_comb begin
    left  = (col_r != '0) ? l_r : c_r;
    right = (col_r < wm1) ? r_r : c_r;
    above = (cmd_r || row_count_r >= 9'd2) ? a_r : c_r;
    below = cmd_r ? c_r : raw_r;
    push_data.dx   = $signed({left[7], left}) - $signed({right[7], right});
    push_data.dz   = $signed({above[7], above}) - $signed({below[7], below});
    push_data.last = cmd_r && (col_r == wm1);
  end

  // State and grid counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hnorm_pkg::FR_IDLE;
      col_count_r <= '0;
      row_count_r <= '0;
      flush_col_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (go) begin
        if (!cmd_r) begin
          if (col_r == wm1) begin
            col_count_r <= '0;
            row_count_r <= row_count_r + 9'd1;
          end else begin
            col_count_r <= col_r + CW'(1);
          end
        end else if (col_r == wm1) begin
          flush_col_r <= '0;
          row_count_r <= '0;
          col_count_r <= '0;
        end else begin
          flush_col_r <= col_r + CW'(1);
        end
      end
    end
  end

endmodule

// ===== hdl/hnorm_queue.sv =====
// ----------------------------------------------------------------------------
// hnorm_queue
// Two-entry queue of height differences between the front and the
// normalization back end.
// ----------------------------------------------------------------------------
module hnorm_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  hnorm_pkg::hnorm_diff_t push_data,
  output logic                   pop_valid,
  input  logic                   pop_ready,
  output hnorm_pkg::hnorm_diff_t pop_data
);

  hnorm_pkg::hnorm_diff_t entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_data;
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/hnorm_back.sv =====
// ----------------------------------------------------------------------------
// hnorm_back
// Scales the height differences by the gains, normalizes the vector to unit
// length with a bit-serial square root and a restoring divider, and holds
// the result in an output register.
// ----------------------------------------------------------------------------
module hnorm_back #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  hnorm_pkg::hnorm_diff_t pop_data,
  input  hnorm_pkg::hnorm_cfg_t  cfg,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [15:0]     out_normal_x,
  output logic [14:0]            out_normal_y,
  output logic signed [15:0]     out_normal_z,
  output logic                   out_grid_last
);

  localparam int F  = NORMAL_FRAC_BITS;
  localparam int QB = F + 2;
  localparam int QW = F + 1;
  localparam int NW = hnorm_pkg::MAG_W + F + 8;
  localparam int IW = $clog2(QB);
  localparam int MW = hnorm_pkg::MAG_W;
  localparam logic [QW-1:0] ONE = {1'b1, {F{1'b0}}};

  hnorm_pkg::hnorm_back_state_t state_r, state_nxt;

  logic [MW-1:0]     ax_r, ay_r, az_r, sq_op, dv_op, mx, mz;
  logic              negx_r, negz_r, last_r;
  logic [1:0]        cnt_r;
  logic [2*MW-1:0]   prod_r;
  logic [2*MW+1:0]   acc_r;
  logic [63:0]       v_r, root_r, bitv, tsum;
  logic [4:0]        rk_r;
  logic [31:0]       rem_r;
  logic [QB-1:0]     nlow_r, q_r, q_fin;
  logic [IW-1:0]     qi_r;
  logic [QW-1:0]     resx_r, resy_r, resz_r, q_sat;
  logic [NW-1:0]     num;
  logic [32:0]       trial;
  logic              qbit, is_zero, top_set, div_end, out_free, out_load;
  logic [8:0]        dxa, dza;

  // Gain multiply on the magnitudes of the differences.
  always_comb begin
    dxa = pop_data.dx[8] ? 9'(-pop_data.dx) : 9'(pop_data.dx);
    dza = pop_data.dz[8] ? 9'(-pop_data.dz) : 9'(pop_data.dz);
    mx  = dxa[7:0] * cfg.x_gain;
    mz  = dza[7:0] * cfg.z_gain;
  end

  // Operand selection, square root step and divider step.
  always_comb begin
    is_zero = ((ax_r | ay_r | az_r) == '0);
    top_set = ax_r[MW-1] | ay_r[MW-1] | az_r[MW-1];
    case (cnt_r)
      2'd0:    sq_op = ax_r;
      2'd1:    sq_op = ay_r;
      default: sq_op = az_r;
    endcase
    dv_op   = sq_op;
    bitv    = 64'(1) << {rk_r, 1'b0};
    tsum    = root_r + bitv;
    num     = (NW'(dv_op) << (F + 7)) + NW'(root_r[31:1]);
    trial   = {rem_r, nlow_r[QB-1]};
    qbit    = (trial >= {1'b0, root_r[31:0]});
    q_fin   = {q_r[QB-2:0], qbit};
    q_sat   = (q_fin > QB'(ONE)) ? ONE : QW'(q_fin);
    div_end = (qi_r == IW'(QB - 1));
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hnorm_pkg::BK_IDLE:  if (pop_valid) state_nxt = hnorm_pkg::BK_NORM;
      hnorm_pkg::BK_NORM: begin
        if (is_zero) begin
          state_nxt = hnorm_pkg::BK_DONE;
        end else if (top_set) begin
          state_nxt = hnorm_pkg::BK_SQ;
        end
      end
      hnorm_pkg::BK_SQ:    if (cnt_r == 2'd3) state_nxt = hnorm_pkg::BK_ROOT;
      hnorm_pkg::BK_ROOT:  if (rk_r == '0) state_nxt = hnorm_pkg::BK_DLOAD;
      hnorm_pkg::BK_DLOAD: state_nxt = hnorm_pkg::BK_DIV;
      hnorm_pkg::BK_DIV: begin
        if (div_end) begin
          state_nxt = (cnt_r == 2'd2) ? hnorm_pkg::BK_DONE : hnorm_pkg::BK_DLOAD;
        end
      end
      hnorm_pkg::BK_DONE:  if (out_free) state_nxt = hnorm_pkg::BK_IDLE;
      default:             state_nxt = hnorm_pkg::BK_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    out_free  = !out_valid || out_ready;
    pop_ready = (state_r == hnorm_pkg::BK_IDLE);
    out_load  = (state_r == hnorm_pkg::BK_DONE) && out_free;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      hnorm_pkg::BK_IDLE: begin
        ax_r   <= mx;
        ay_r   <= MW'(cfg.up_component);
        az_r   <= mz;
        negx_r <= pop_data.dx[8];
        negz_r <= pop_data.dz[8];
        last_r <= pop_data.last;
      end
      hnorm_pkg::BK_NORM: begin
        if (is_zero) begin
          resx_r <= '0;
          resy_r <= ONE;
          resz_r <= '0;
        end else if (!top_set) begin
          ax_r <= ax_r << 1;
          ay_r <= ay_r << 1;
          az_r <= az_r << 1;
        end
      end
      hnorm_pkg::BK_SQ: begin
        // One square per cycle, summed in the cycle after.
        prod_r <= sq_op * sq_op;
        if (cnt_r == 2'd1) acc_r <= (2 * MW + 2)'(prod_r);
        if (cnt_r == 2'd2) acc_r <= acc_r + (2 * MW + 2)'(prod_r);
        if (cnt_r == 2'd3) begin
          v_r    <= {14'(0), 50'(acc_r + (2 * MW + 2)'(prod_r))} << 14;
          root_r <= '0;
          rk_r   <= 5'd31;
        end
      end
      hnorm_pkg::BK_ROOT: begin
        if (v_r >= tsum) begin
          v_r    <= v_r - tsum;
          root_r <= (root_r >> 1) + bitv;
        end else begin
          root_r <= root_r >> 1;
        end
        rk_r <= rk_r - 5'd1;
      end
      hnorm_pkg::BK_DLOAD: begin
        rem_r  <= 32'(num >> QB);
        nlow_r <= num[QB-1:0];
        q_r    <= '0;
        qi_r   <= '0;
      end
      hnorm_pkg::BK_DIV: begin
        rem_r  <= qbit ? 32'(trial - {1'b0, root_r[31:0]}) : trial[31:0];
        nlow_r <= nlow_r << 1;
        q_r    <= q_fin;
        qi_r   <= qi_r + IW'(1);
        if (div_end) begin
          case (cnt_r)
            2'd0:    resx_r <= q_sat;
            2'd1:    resy_r <= q_sat;
            default: resz_r <= q_sat;
          endcase
        end
      end
      default: begin
        rem_r <= rem_r;
      end
    endcase
    if (out_load) begin
      out_normal_x  <= negx_r ? 16'(0) - 16'(resx_r) : 16'(resx_r);
      out_normal_y  <= 15'(resy_r);
      out_normal_z  <= negz_r ? 16'(0) - 16'(resz_r) : 16'(resz_r);
      out_grid_last <= last_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= hnorm_pkg::BK_IDLE;
      cnt_r     <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == hnorm_pkg::BK_IDLE) begin
        cnt_r <= 2'd0;
      end else if (state_r == hnorm_pkg::BK_SQ) begin
        cnt_r <= (cnt_r == 2'd3) ? 2'd0 : cnt_r + 2'd1;
      end else if (state_r == hnorm_pkg::BK_DIV && div_end) begin
        cnt_r <= cnt_r + 2'd1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/heightfield_normal_generator_top.sv =====
// ----------------------------------------------------------------------------
// heightfield_normal_generator_top
// Unit surface normals of a height grid, one row behind the samples.
//
// Height samples enter in raster order on the in_ channel (in_command low);
// flush ticks (in_command high) emit the bottom row once the grid is
// complete. Each sample of a row after the first, and each flush tick of the
// bottom row, yields one normal on the out_ channel; other items give none.
// The front takes one item at a time, its neighbour fetch set by the single
// read port of each line store. The back end works on one normal at a time:
// a normalizing shift k (0 to 23), a 32-step square root and three
// divisions, one quotient bit per cycle. The back end sets the sustained rate.
// A two-entry queue lets the front run ahead of the back end, and the output
// register lets the back end finish the next normal while the receiver
// stalls. Reset clears the counters and empties the pipe; the line stores
// need no clearing. Configuration transactions are taken at any time and
// must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module heightfield_normal_generator_top #(
  parameter int MAX_WIDTH        = 256,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_command,
  input  logic signed [hnorm_pkg::SAMPLE_W-1:0] in_height_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [15:0]                    out_normal_x,
  output logic [14:0]                           out_normal_y,
  output logic signed [15:0]                    out_normal_z,
  output logic                                  out_grid_last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [hnorm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [15:0]                           cfg_data
);

  hnorm_pkg::hnorm_cfg_t  cfg_r;
  hnorm_pkg::hnorm_diff_t q_push_data, q_pop_data;
  logic                   q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_width   <= 9'd2;
      cfg_r.grid_height  <= 9'd2;
      cfg_r.x_gain       <= 16'd256;
      cfg_r.z_gain       <= 16'd256;
      cfg_r.up_component <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hnorm_pkg::CFG_GRID_WIDTH:  cfg_r.grid_width   <= cfg_data[8:0];
        hnorm_pkg::CFG_GRID_HEIGHT: cfg_r.grid_height  <= cfg_data[8:0];
        hnorm_pkg::CFG_X_GAIN:      cfg_r.x_gain       <= cfg_data;
        hnorm_pkg::CFG_Z_GAIN:      cfg_r.z_gain       <= cfg_data;
        hnorm_pkg::CFG_UP_COMP:     cfg_r.up_component <= cfg_data;
        default:                    cfg_r <= cfg_r;
      endcase
    end
  end

  // Front: line stores and neighbour fetch.
  hnorm_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_height_sample (in_height_sample),
    .cfg              (cfg_r),
    .push_valid       (q_push_valid),
    .push_ready       (q_push_ready),
    .push_data        (q_push_data)
  );

  // Decoupling queue.
  hnorm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  // Back: scaling and normalization.
  hnorm_back #(
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (q_pop_valid),
    .pop_ready     (q_pop_ready),
    .pop_data      (q_pop_data),
    .cfg           (cfg_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_normal_x  (out_normal_x),
    .out_normal_y  (out_normal_y),
    .out_normal_z  (out_normal_z),
    .out_grid_last (out_grid_last)
  );

  // Reset leaves the queue and the output register empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !q_pop_valid)
    else $error("queue or output not empty after reset");

  // The back end leaves its idle state after taking an entry, so it never takes two in a row.
  a_back_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop_valid && q_pop_ready |=> !q_pop_ready)
    else $error("back end took two entries in a row");

  // The front accepts nothing while it offers a difference record.
  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    q_push_valid |-> !in_ready)
    else $error("front accepted a transaction while pushing");

endmodule

// ===== dv/heightfield_normal_generator_top_tb.sv =====
// ----------------------------------------------------------------------------
// heightfield_normal_generator_top_tb
// Self-checking bench for the heightfield normal generator. Height grids and
// flush ticks are streamed under random gaps on both channels; every normal
// is compared against a behavioral model of the central-difference and
// normalization arithmetic, across several grid sizes and gain settings.
// ----------------------------------------------------------------------------
module heightfield_normal_generator_top_tb;

  localparam int MAXW     = 256;
  localparam int FRAC     = 14;
  localparam int LIMIT    = 20000;
  localparam bit CMD_SAMPLE = 1'b0;
  localparam bit CMD_FLUSH  = 1'b1;

  typedef struct packed {
    logic signed [15:0] nx;
    logic [14:0]        ny;
    logic signed [15:0] nz;
    logic               last;
  } normal_t;

  typedef struct {
    bit              cmd;
    logic [7:0]      hgt;
    bit              known;
    normal_t         nrm;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_command = 1'b0;
  logic signed [7:0] in_height_sample = '0;
  logic in_ready;
  logic out_valid, out_ready = 1'b0;
  logic signed [15:0] out_normal_x, out_normal_z;
  logic [14:0] out_normal_y;
  logic out_grid_last;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [hnorm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Model state: configuration, line stores and counters.
  int unsigned m_width, m_height, m_xgain, m_zgain, m_up;
  logic [7:0] prev_row [MAXW];
  logic [7:0] old_row [MAXW];
  int unsigned col_cnt, row_cnt, flush_col;

  normal_t pending_normals[$];
  int errors = 0;
  int normals_seen = 0;
  int idle_cycles = 0;
  int grids_done = 0;
  bit sink_hold = 1'b0;

  heightfield_normal_generator_top DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > LIMIT) begin
      $display("heightfield_normal_generator_top_tb failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned scaled(longint unsigned a, longint unsigned len);
    longint unsigned q;
    q = ((a << (FRAC + 7)) + (len >> 1)) / len;
    if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
    return q;
  endfunction

  // Unit normal of the raw vector (dx * x_gain, up, dz * z_gain).
  function automatic normal_t unit_normal(int dx, int dz, bit last);
    normal_t n;
    longint vx, vz;
    longint unsigned ax, ay, az, mx, len;
    vx = longint'(dx) * m_xgain;
    vz = longint'(dz) * m_zgain;
    ax = vx < 0 ? -vx : vx;
    ay = m_up;
    az = vz < 0 ? -vz : vz;
    mx = ax;
    if (ay > mx) mx = ay;
    if (az > mx) mx = az;
    n.last = last;
    if (mx == 0) begin
      n.nx = 0;
      n.ny = 15'(1 << FRAC);
      n.nz = 0;
      return n;
    end
    while (mx < (64'd1 << 23)) begin
      ax <<= 1; ay <<= 1; az <<= 1; mx <<= 1;
    end
    len = int_sqrt((ax * ax + ay * ay + az * az) << 14);
    n.nx = 16'(scaled(ax, len));
    if (vx < 0) n.nx = -n.nx;
    n.ny = 15'(scaled(ay, len));
    n.nz = 16'(scaled(az, len));
    if (vz < 0) n.nz = -n.nz;
    return n;
  endfunction

  function automatic int sh(logic [7:0] b);
    return int'($signed(b));
  endfunction

  // Advance the model by one accepted item; queue a normal if one results.
  task automatic predict_item(bit cmd, logic [7:0] hgt);
    int unsigned w, h, c;
    int cv, lv, rv, av;
    w = m_width > MAXW ? MAXW : (m_width < 2 ? 2 : m_width);
    h = m_height < 2 ? 2 : m_height;
    if (cmd == CMD_SAMPLE) begin
      if (row_cnt >= h) return;
      c = col_cnt > w - 1 ? w - 1 : col_cnt;
      if (row_cnt >= 1) begin
        cv = sh(prev_row[c]);
        lv = c > 0 ? sh(old_row[c-1]) : cv;
        rv = c < w - 1 ? sh(prev_row[c+1]) : cv;
        av = row_cnt >= 2 ? sh(old_row[c]) : cv;
        pending_normals.push_back(unit_normal(lv - rv, av - sh(hgt), 1'b0));
      end
      old_row[c] = prev_row[c];
      prev_row[c] = hgt;
      if (c == w - 1) begin
        col_cnt = 0;
        row_cnt = (row_cnt + 1) & 9'h1FF;
      end else col_cnt = c + 1;
    end else begin
      if (row_cnt < h) return;
      c = flush_col > w - 1 ? w - 1 : flush_col;
      cv = sh(prev_row[c]);
      lv = c > 0 ? sh(prev_row[c-1]) : cv;
      rv = c < w - 1 ? sh(prev_row[c+1]) : cv;
      av = sh(old_row[c]);
      pending_normals.push_back(unit_normal(lv - rv, av - cv, c == w - 1));
      if (c == w - 1) begin
        flush_col = 0; row_cnt = 0; col_cnt = 0;
        grids_done++;
      end else flush_col = c + 1;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on normal %0d: %s got %0d expected %0d", normals_seen, what, got, want);
    errors++;
  endtask

  // Result checker; directed rows with typed-in values are checked twice over.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      normal_t e;
      if (pending_normals.size() == 0) begin
        report_mismatch("unexpected normal transaction, pending count", 1, 0);
      end else begin
        e = pending_normals.pop_front();
        if (out_normal_x !== e.nx) report_mismatch("normal_x", out_normal_x, e.nx);
        if (out_normal_y !== e.ny) report_mismatch("normal_y", out_normal_y, e.ny);
        if (out_normal_z !== e.nz) report_mismatch("normal_z", out_normal_z, e.nz);
        if (out_grid_last !== e.last) report_mismatch("grid_last", out_grid_last, e.last);
      end
      normals_seen++;
    end
  end

  // Receiver with random stalls.
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      g = sink_hold ? 0 : gap_len();
      out_ready <= (g == 0);
      repeat (g) @(posedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic write_reg(logic [hnorm_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      hnorm_pkg::CFG_GRID_WIDTH:  m_width  = val & 9'h1FF;
      hnorm_pkg::CFG_GRID_HEIGHT: m_height = val & 9'h1FF;
      hnorm_pkg::CFG_X_GAIN:      m_xgain  = val;
      hnorm_pkg::CFG_Z_GAIN:      m_zgain  = val;
      hnorm_pkg::CFG_UP_COMP:     m_up     = val;
      default: ;
    endcase
  endtask

  task automatic send_item(bit cmd, logic [7:0] hgt, bit use_gaps);
    int g;
    g = use_gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_height_sample <= hgt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(cmd, hgt);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_normals.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic configure(int w, int h, int xg, int zg, int up);
    write_reg(hnorm_pkg::CFG_GRID_WIDTH, 16'(w));
    write_reg(hnorm_pkg::CFG_GRID_HEIGHT, 16'(h));
    write_reg(hnorm_pkg::CFG_X_GAIN, 16'(xg));
    write_reg(hnorm_pkg::CFG_Z_GAIN, 16'(zg));
    write_reg(hnorm_pkg::CFG_UP_COMP, 16'(up));
  endtask

  // One complete grid with random heights, then its flush, plus a little noise.
  task automatic random_grid(inout int sent, input int hmode);
    int w, h;
    w = m_width > MAXW ? MAXW : (m_width < 2 ? 2 : m_width);
    h = m_height < 2 ? 2 : m_height;
    if ($urandom_range(0, 9) == 0) begin
      send_item(CMD_FLUSH, 8'($urandom), 1'b1);
      sent++;
    end
    for (int i = 0; i < w * h; i++) begin
      send_item(CMD_SAMPLE, hmode == 0 ? 8'($urandom) : 8'($urandom_range(0, 1) ? 8'h7F : 8'h80),
                1'b1);
      sent++;
    end
    if ($urandom_range(0, 9) == 0) send_item(CMD_SAMPLE, 8'($urandom), 1'b1);
    for (int i = 0; i < w; i++) begin
      send_item(CMD_FLUSH, 8'($urandom), 1'b1);
      sent++;
    end
  endtask

  // Directed table: a 2x2 grid, flat ground and extremes, then flush.
  stim_row_t directed [] = '{
    '{CMD_FLUSH,  8'h00, 1'b0, '{0, 0, 0, 0}},
    '{CMD_SAMPLE, 8'h7F, 1'b0, '{0, 0, 0, 0}},
    '{CMD_SAMPLE, 8'h80, 1'b0, '{0, 0, 0, 0}},
    '{CMD_SAMPLE, 8'h80, 1'b0, '{0, 0, 0, 0}},
    '{CMD_SAMPLE, 8'h7F, 1'b0, '{0, 0, 0, 0}},
    '{CMD_SAMPLE, 8'h55, 1'b0, '{0, 0, 0, 0}},
    '{CMD_FLUSH,  8'hFF, 1'b0, '{0, 0, 0, 0}},
    '{CMD_FLUSH,  8'h00, 1'b0, '{0, 0, 0, 0}},
    // Flat 2x2 grid with zero up component: the zero-vector default.
    '{CMD_SAMPLE, 8'h00, 1'b0, '{0, 0, 0, 0}},
    '{CMD_SAMPLE, 8'h00, 1'b0, '{0, 0, 0, 0}},
    '{CMD_SAMPLE, 8'h00, 1'b1, '{16'sd0, 15'd16384, 16'sd0, 1'b0}},
    '{CMD_SAMPLE, 8'h00, 1'b1, '{16'sd0, 15'd16384, 16'sd0, 1'b0}},
    '{CMD_FLUSH,  8'h00, 1'b1, '{16'sd0, 15'd16384, 16'sd0, 1'b0}},
    '{CMD_FLUSH,  8'h00, 1'b1, '{16'sd0, 15'd16384, 16'sd0, 1'b1}}
  };

  initial begin
    int sent;
    int hmode;
    m_width = 2; m_height = 2; m_xgain = 256; m_zgain = 256; m_up = 256;
    col_cnt = 0; row_cnt = 0; flush_col = 0;
    foreach (prev_row[i]) begin
      prev_row[i] = '0;
      old_row[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with steep gains; the flat grid runs with a zero up component.
    configure(2, 2, 65535, 65535, 1);
    foreach (directed[i]) begin
      if (i == 8) begin
        drain();
        write_reg(hnorm_pkg::CFG_UP_COMP, 16'd0);
      end
      send_item(directed[i].cmd, directed[i].hgt, 1'b0);
      if (directed[i].known) begin
        normal_t p;
        p = pending_normals[pending_normals.size() - 1];
        if (p.nx !== directed[i].nrm.nx)
          report_mismatch("directed table normal_x", p.nx, directed[i].nrm.nx);
        if (p.ny !== directed[i].nrm.ny)
          report_mismatch("directed table normal_y", p.ny, directed[i].nrm.ny);
        if (p.nz !== directed[i].nrm.nz)
          report_mismatch("directed table normal_z", p.nz, directed[i].nrm.nz);
        if (p.last !== directed[i].nrm.last)
          report_mismatch("directed table grid_last", p.last, directed[i].nrm.last);
      end
    end
    drain();

    // Random part across several register settings.
    sent = 0;
    for (int phase = 0; sent < 1800; phase++) begin
      case (phase % 6)
        0: configure(2, 2, 0, 0, 65535);
        1: configure($urandom_range(2, 12), $urandom_range(2, 6),
                     $urandom, $urandom, $urandom_range(1, 65535));
        2: configure(256, 2, $urandom_range(0, 512), $urandom_range(0, 512),
                     $urandom_range(1, 512));
        3: configure($urandom_range(0, 1), $urandom_range(0, 1), 256, 256, 256);
        4: configure($urandom_range(3, 9), $urandom_range(2, 4),
                     65535, 65535, 1);
        default: configure($urandom_range(2, 16), $urandom_range(2, 5),
                           $urandom_range(0, 4096), $urandom_range(0, 4096),
                           $urandom_range(1, 4096));
      endcase
      hmode = $urandom_range(0, 3) == 0;
      sink_hold = (phase % 4 == 1);
      random_grid(sent, hmode);
      if (phase % 5 == 2) begin
        // Sender holds off until every normal has come back.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_normals.size() != 0) @(posedge clk);
      end
      drain();
    end

    drain();
    $display("covered %0d input items over %0d complete grids", sent, grids_done);
    $display("checked %0d normals, %0d mismatches", normals_seen, errors);
    if (errors == 0 && pending_normals.size() == 0) begin
      $display("heightfield_normal_generator_top_tb passed");
    end else begin
      $display("heightfield_normal_generator_top_tb failed");
    end
    $finish;
  end

endmodule
